[src/lbachs_pkg.sv]
// ---------------------------------------------------------------------------
// lbachs_pkg
// shared types, codes and sizes of the lba to chs request splitter
// ---------------------------------------------------------------------------
`default_nettype none

package lbachs_pkg;

    // request limits
    localparam int MAX_REQUEST_SECTORS = 64;
    localparam int COUNT_W             = 7;
    localparam int LBA_W               = 32;
    localparam int GEOM_W              = 6;
    localparam int HEADS_W             = 5;
    localparam logic [HEADS_W-1:0] HEADS_MAX = 5'd16;

    // serial divider
    localparam int DIV_STEPS = LBA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // stream widths
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READY  = 3'd0,
        CFG_SPT0   = 3'd1,
        CFG_HEADS0 = 3'd2,
        CFG_SPT1   = 3'd3,
        CFG_HEADS1 = 3'd4
    } t_cfg_idx;

    // ata command and drive/head byte
    localparam logic [7:0] ATA_CMD_READ  = 8'h20;
    localparam logic [7:0] ATA_CMD_WRITE = 8'h30;
    localparam logic [7:0] ATA_DH_BASE   = 8'hA0;

    typedef enum logic [2:0] {
        ST_CMD       = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_NO_DRIVE  = 3'd2,
        ST_BAD_PART  = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // classified request handed from front to back
    typedef struct packed {
        t_status              status;
        logic                 is_write;
        logic                 drive;
        logic [LBA_W-1:0]     start;
        logic [COUNT_W-1:0]   count;
        logic [GEOM_W-1:0]    spt;
        logic [HEADS_W-1:0]   heads;
    } t_req_desc;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV_SPT,
        BK_DIV_HEADS,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

[src/lba_to_chs_request_splitter_unit.sv]
// ---------------------------------------------------------------------------
// lba_to_chs_request_splitter_unit
// checks disk requests and turns them into per-track ata chs commands
// ---------------------------------------------------------------------------
// A request names a drive, read or write, a start sector relative to its
// partition, a sector count and the partition's base, length and valid mark.
// The front end checks it against the geometry registers (ready flag, sectors
// per track and heads of drives 0 and 1) and queues it; a rejected or empty
// request gives one response with only its status and tlast set. A good
// request is cut to at most 64 sectors, moved by the partition base and split
// at track ends; each piece becomes one ata command response (count, 1-based
// sector, cylinder, drive/head byte, offset), the last one marked by tlast.
// Each piece goes through a start step (first piece of a request only), the
// one-bit-per-cycle serial divider in the back end dividing the start by the
// sectors per track for the sector split and the quotient by the heads for the
// head split, and a load of the output register; a rejected request goes
// straight to the output register. A two-entry queue lets new requests be taken
// while an earlier one is still being split, and the output register lets the
// back end run on while a response waits to be taken. Geometry registers may
// be written only while no request is in flight; the config port never stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module lba_to_chs_request_splitter_unit
    import lbachs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // request stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // rel_start[31:0], req_sectors[38:32], part_base[70:39],
    // part_length[102:71], part_valid[103]
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // drive_sel[1:0], is_write[2]
    input  wire logic [S_TUSER_W-1:0]  i_s_axis_tuser,
    // response stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // command_byte[7:0], pass_sectors[13:8], sector_number[19:14],
    // cylinder_number[35:20], drive_head_byte[43:36], buffer_offset[49:44],
    // zero fill[55:50]
    output logic [M_TDATA_W-1:0]       o_m_axis_tdata,
    // status[2:0]
    output logic [M_TUSER_W-1:0]       o_m_axis_tuser,
    output logic                       o_m_axis_tlast
);

    // front to queue
    logic      q_push;
    t_req_desc q_in_desc;
    logic      q_full;

    // queue to back
    logic      q_pop;
    t_req_desc q_out_desc;
    logic      q_empty;

    // check and classify, geometry registers live here
    lbachs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_desc        (q_in_desc)
    );

    // decouples request intake from splitting
    lbachs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in_desc),
        .i_pop   (q_pop),
        .o_desc  (q_out_desc),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // per-track split and chs translation
    lbachs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_desc          (q_out_desc),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

[src/lbachs_front.sv]
// ---------------------------------------------------------------------------
// lbachs_front
// holds the geometry registers, takes requests and classifies them
// ---------------------------------------------------------------------------
`default_nettype none

module lbachs_front
    import lbachs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic [S_TUSER_W-1:0]  i_s_axis_tuser,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output t_req_desc                  o_q_desc
);

    logic               r_ready;
    logic [GEOM_W-1:0]  r_spt0;
    logic [HEADS_W-1:0] r_heads0;
    logic [GEOM_W-1:0]  r_spt1;
    logic [HEADS_W-1:0] r_heads1;

    logic [1:0]         drive_sel;
    logic               is_write;
    logic [LBA_W-1:0]   rel_start;
    logic [COUNT_W-1:0] req_sectors;
    logic [LBA_W-1:0]   part_base;
    logic [LBA_W-1:0]   part_length;
    logic               part_valid;
    logic [GEOM_W-1:0]  spt;
    logic [HEADS_W-1:0] heads;
    t_status            status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_spt0   <= '0;
            r_heads0 <= '0;
            r_spt1   <= '0;
            r_heads1 <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_READY:  r_ready  <= i_cfg_data[0];
                CFG_SPT0:   r_spt0   <= i_cfg_data;
                CFG_HEADS0: r_heads0 <= i_cfg_data[HEADS_W-1:0];
                CFG_SPT1:   r_spt1   <= i_cfg_data;
                CFG_HEADS1: r_heads1 <= i_cfg_data[HEADS_W-1:0];
                default: ;
            endcase
        end
    end

    assign drive_sel   = i_s_axis_tuser[1:0];
    assign is_write    = i_s_axis_tuser[2];
    assign rel_start   = i_s_axis_tdata[31:0];
    assign req_sectors = i_s_axis_tdata[38:32];
    assign part_base   = i_s_axis_tdata[70:39];
    assign part_length = i_s_axis_tdata[102:71];
    assign part_valid  = i_s_axis_tdata[103];

    always_comb begin
        case (drive_sel)
            2'd0: begin
                spt   = r_spt0;
                heads = r_heads0;
            end
            2'd1: begin
                spt   = r_spt1;
                heads = r_heads1;
            end
            default: begin
                spt   = '0;
                heads = '0;
            end
        endcase

        if (!r_ready) begin
            status = ST_NOT_READY;
        end else if (spt == '0 || heads == '0) begin
            status = ST_NO_DRIVE;
        end else if (!part_valid || part_length < rel_start) begin
            status = ST_BAD_PART;
        end else if (req_sectors == '0) begin
            status = ST_EMPTY;
        end else begin
            status = ST_CMD;
        end
    end

    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_q_desc          = '0;
        o_q_desc.status   = status;
        o_q_desc.is_write = is_write;
        o_q_desc.drive    = drive_sel[0];
        o_q_desc.start    = part_base + rel_start;
        o_q_desc.count    = (req_sectors > COUNT_W'(MAX_REQUEST_SECTORS))
                          ? COUNT_W'(MAX_REQUEST_SECTORS) : req_sectors;
        o_q_desc.spt      = spt;
        o_q_desc.heads    = (heads > HEADS_MAX) ? HEADS_MAX : heads;
    end

endmodule

`default_nettype wire

[src/lbachs_queue.sv]
// ---------------------------------------------------------------------------
// lbachs_queue
// two-entry queue of classified requests between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module lbachs_queue
    import lbachs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_req_desc i_desc,
    input  wire logic      i_pop,
    output t_req_desc      o_desc,
    output logic           o_empty,
    output logic           o_full
);

    t_req_desc  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_empty = (r_fill == 2'd0);
    assign o_full  = (r_fill == 2'd2);
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/lbachs_back.sv]
// ---------------------------------------------------------------------------
// lbachs_back
// splits a request at track ends and translates each piece to chs
// ---------------------------------------------------------------------------
`default_nettype none

module lbachs_back
    import lbachs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_req_desc            i_desc,
    input  wire logic                 i_q_empty,
    output logic                      o_q_pop,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,
    output logic [M_TUSER_W-1:0]      o_m_axis_tuser,
    output logic                      o_m_axis_tlast
);

    t_back_state        r_state, n_state;
    t_status            r_status, n_status;
    logic               r_wr, n_wr;
    logic               r_drv, n_drv;
    logic [LBA_W-1:0]   r_start, n_start;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_done, n_done;
    logic [GEOM_W-1:0]  r_spt, n_spt;
    logic [HEADS_W-1:0] r_heads, n_heads;
    logic [GEOM_W-1:0]  r_sec_rem, n_sec_rem;

    // shared restoring divider
    logic [LBA_W-1:0]     r_dvd, n_dvd;
    logic [GEOM_W-1:0]    r_rem, n_rem;
    logic [GEOM_W-1:0]    r_div, n_div;
    logic [DIV_CNT_W-1:0] r_step, n_step;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;
    logic [M_TUSER_W-1:0] r_out_user, n_out_user;
    logic                 r_out_last, n_out_last;

    logic [GEOM_W:0]      trial;
    logic [GEOM_W:0]      trial_diff;
    logic                 trial_ge;
    logic [GEOM_W-1:0]    step_rem;
    logic [LBA_W-1:0]     step_dvd;
    logic                 div_last;
    logic                 out_free;
    logic [GEOM_W-1:0]    room;
    logic [GEOM_W-1:0]    pass;
    logic [LBA_W-1:0]     next_start;
    logic [7:0]           cmd_byte;
    logic [7:0]           dh_byte;

    assign trial      = {r_rem, r_dvd[LBA_W-1]};
    assign trial_diff = trial - {1'b0, r_div};
    assign trial_ge   = (trial >= {1'b0, r_div});
    assign step_rem   = trial_ge ? trial_diff[GEOM_W-1:0] : trial[GEOM_W-1:0];
    assign step_dvd   = {r_dvd[LBA_W-2:0], trial_ge};
    assign div_last   = (r_step == DIV_CNT_W'(DIV_STEPS - 1));

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign room       = r_spt - r_sec_rem;
    assign pass       = (r_count <= {1'b0, room}) ? r_count[GEOM_W-1:0] : room;
    assign next_start = r_start + {{(LBA_W-GEOM_W){1'b0}}, pass};
    assign cmd_byte   = r_wr ? ATA_CMD_WRITE : ATA_CMD_READ;
    assign dh_byte    = ATA_DH_BASE | {3'b000, r_drv, r_rem[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_wr       <= n_wr;
        r_drv      <= n_drv;
        r_start    <= n_start;
        r_count    <= n_count;
        r_done     <= n_done;
        r_spt      <= n_spt;
        r_heads    <= n_heads;
        r_sec_rem  <= n_sec_rem;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_step     <= n_step;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_wr        = r_wr;
        n_drv       = r_drv;
        n_start     = r_start;
        n_count     = r_count;
        n_done      = r_done;
        n_spt       = r_spt;
        n_heads     = r_heads;
        n_sec_rem   = r_sec_rem;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_div       = r_div;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    n_status = i_desc.status;
                    n_wr     = i_desc.is_write;
                    n_drv    = i_desc.drive;
                    n_start  = i_desc.start;
                    n_count  = i_desc.count;
                    n_done   = '0;
                    n_spt    = i_desc.spt;
                    n_heads  = i_desc.heads;
                    n_dvd    = i_desc.start;
                    n_rem    = '0;
                    n_div    = i_desc.spt;
                    n_step   = '0;
                    n_state  = (i_desc.status == ST_CMD) ? BK_DIV_SPT : BK_EMIT;
                end
            end
            BK_DIV_SPT: begin
                n_dvd  = step_dvd;
                n_rem  = step_rem;
                n_step = r_step + 1'b1;
                if (div_last) begin
                    // quotient stays in the dividend register for the head split
                    n_sec_rem = step_rem;
                    n_rem     = '0;
                    n_div     = {1'b0, r_heads};
                    n_step    = '0;
                    n_state   = BK_DIV_HEADS;
                end
            end
            BK_DIV_HEADS: begin
                n_dvd  = step_dvd;
                n_rem  = step_rem;
                n_step = r_step + 1'b1;
                if (div_last) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_status;
                    if (r_status != ST_CMD) begin
                        n_out_data = '0;
                        n_out_last = 1'b1;
                        n_state    = BK_IDLE;
                    end else begin
                        n_out_data = {6'b0, r_done[GEOM_W-1:0], dh_byte, r_dvd[15:0],
                                      r_sec_rem + 1'b1, pass, cmd_byte};
                        n_out_last = (r_count == {1'b0, pass});
                        n_count    = r_count - {1'b0, pass};
                        n_done     = r_done + {1'b0, pass};
                        n_start    = next_start;
                        n_dvd      = next_start;
                        n_rem      = '0;
                        n_div      = r_spt;
                        n_step     = '0;
                        n_state    = (r_count == {1'b0, pass}) ? BK_IDLE : BK_DIV_SPT;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[src/lbachs_checker.sv]
// ---------------------------------------------------------------------------
// lbachs_checker
// port-level checks on the response stream of the request splitter
// ---------------------------------------------------------------------------
`default_nettype none

module lbachs_checker
    import lbachs_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] o_m_axis_tuser,
    input wire logic                 o_m_axis_tlast
);

    // a stalled response holds its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled response changed");

    // a status-only response always ends its request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_CMD |->
            o_m_axis_tlast && o_m_axis_tdata == '0)
        else $error("status response not final or not empty");

    // a command response carries a real ata command and drive/head byte and a nonzero count and sector
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_CMD |->
            (o_m_axis_tdata[7:0] == ATA_CMD_READ || o_m_axis_tdata[7:0] == ATA_CMD_WRITE)
            && o_m_axis_tdata[43:41] == ATA_DH_BASE[7:5]
            && o_m_axis_tdata[13:8] != 6'd0 && o_m_axis_tdata[19:14] != 6'd0)
        else $error("malformed command response");

    // a piece that follows straight on an accepted non-final command continues the same request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser == ST_CMD
        && !o_m_axis_tlast ##1 o_m_axis_tvalid |->
            o_m_axis_tuser == ST_CMD
            && o_m_axis_tdata[7:0] == $past(o_m_axis_tdata[7:0])
            && o_m_axis_tdata[49:44] == $past(o_m_axis_tdata[49:44])
                + $past(o_m_axis_tdata[13:8]))
        else $error("split pieces out of step");

endmodule

bind lba_to_chs_request_splitter_unit lbachs_checker u_lbachs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
